### src/mpcs_pkg.sv
// ----------------------------------------------------------------------------
// mpcs_pkg
// Types, codes and helper functions shared by the scheduler modules.
// ----------------------------------------------------------------------------
package mpcs_pkg;

    localparam logic [2:0] POL_FCFS = 3'd0;
    localparam logic [2:0] POL_SJF  = 3'd1;
    localparam logic [2:0] POL_PRIO = 3'd2;
    localparam logic [2:0] POL_RR   = 3'd3;
    localparam logic [2:0] POL_SRTF = 3'd4;
    localparam logic [2:0] POL_PPRI = 3'd5;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_SLICE  = 1'b1;

    localparam logic [1:0] RD_IDX  = 2'd0;
    localparam logic [1:0] RD_NEXT = 2'd1;
    localparam logic [1:0] RD_BEST = 2'd2;

    typedef struct packed {
        logic [7:0]  pid;
        logic [15:0] arrival;
        logic [15:0] burst_total;
        logic [15:0] remaining;
        logic [7:0]  priority_val;
    } rec_t;

    typedef struct packed {
        logic       clr;
        logic       push_in;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       pick_eval;
        logic       idx_inc;
        logic       idx_best;
        logic       take_ld;
        logic       shift_wr;
        logic       cnt_dec;
        logic       run;
        logic       idx_clr;
        logic       chk_eval;
        logic       requeue;
        logic       done;
    } cmd_t;

    typedef struct packed {
        logic cur_valid;
        logic has_entries;
        logic is_rr;
        logic last;
        logic chk_need;
    } stat_t;

    function automatic logic [15:0] rec_key(rec_t r, logic [2:0] pol);
        logic [15:0] k;
        case (pol)
            POL_SJF:  k = r.burst_total;
            POL_PRIO: k = {8'd0, r.priority_val};
            POL_PPRI: k = {8'd0, r.priority_val};
            POL_SRTF: k = r.remaining;
            default:  k = r.arrival;
        endcase
        return k;
    endfunction

endpackage

### src/mpcs_ctrl.sv
// ----------------------------------------------------------------------------
// mpcs_ctrl
// Sequencer that walks the ready table for picks, compaction and requeue tests.
// ----------------------------------------------------------------------------
module mpcs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              func,
    input  mpcs_pkg::stat_t   stat,
    output mpcs_pkg::cmd_t    cmd,
    output logic              busy
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PICK_RD, ST_PICK_EV, ST_TAKE_RD, ST_TAKE_LD, ST_SHIFT_TST,
        ST_SHIFT_RD, ST_SHIFT_WR, ST_DEC, ST_RUN, ST_CHK_RD, ST_CHK_EV,
        ST_REQ, ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.clr = 1'b1;
                    cmd.idx_clr = 1'b1;
                    if (!func)
                    begin
                        cmd.push_in = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (!stat.cur_valid && stat.has_entries)
                    begin
                        state_next = stat.is_rr ? ST_TAKE_RD : ST_PICK_RD;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_PICK_RD:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = mpcs_pkg::RD_IDX;
                state_next = ST_PICK_EV;
            end
            ST_PICK_EV:
            begin
                cmd.pick_eval = 1'b1;
                if (stat.last)
                begin
                    state_next = ST_TAKE_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = ST_PICK_RD;
                end
            end
            ST_TAKE_RD:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = mpcs_pkg::RD_BEST;
                cmd.idx_best = 1'b1;
                state_next = ST_TAKE_LD;
            end
            ST_TAKE_LD:
            begin
                cmd.take_ld = 1'b1;
                state_next = ST_SHIFT_TST;
            end
            ST_SHIFT_TST:
            begin
                state_next = stat.last ? ST_DEC : ST_SHIFT_RD;
            end
            ST_SHIFT_RD:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = mpcs_pkg::RD_NEXT;
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next = ST_SHIFT_TST;
            end
            ST_DEC:
            begin
                cmd.cnt_dec = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.run = 1'b1;
                cmd.idx_clr = 1'b1;
                state_next = stat.chk_need ? ST_CHK_RD : ST_REQ;
            end
            ST_CHK_RD:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = mpcs_pkg::RD_IDX;
                state_next = ST_CHK_EV;
            end
            ST_CHK_EV:
            begin
                cmd.chk_eval = 1'b1;
                if (stat.last)
                begin
                    state_next = ST_REQ;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = ST_CHK_RD;
                end
            end
            ST_REQ:
            begin
                cmd.requeue = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.done = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

### src/mpcs_dp.sv
// ----------------------------------------------------------------------------
// mpcs_dp
// Ready table memory, running process record, scan registers and result word.
// ----------------------------------------------------------------------------
module mpcs_dp
#(
    parameter int READY_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  mpcs_pkg::cmd_t    cmd,
    output mpcs_pkg::stat_t   stat,
    input  logic [2:0]        pol,
    input  logic [7:0]        time_slice,
    input  logic [7:0]        pid,
    input  logic [15:0]       arrival_time,
    input  logic [15:0]       burst_length,
    input  logic [7:0]        priority_req,
    output logic              done,
    output logic              add_rejected,
    output logic              running_valid,
    output logic [7:0]        running_pid,
    output logic              newly_scheduled,
    output logic              finished,
    output logic              preempted,
    output logic [4:0]        ready_count
);

    localparam int AW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
    localparam int CW = $clog2(READY_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(READY_DEPTH);

    mpcs_pkg::rec_t mem [READY_DEPTH];
    mpcs_pkg::rec_t rd_data_reg;

    logic [CW-1:0]  count_reg;
    logic [AW-1:0]  idx_reg;
    logic [AW-1:0]  best_reg;
    logic [15:0]    min_reg;
    logic           want_reg;
    logic           cur_valid_reg;
    mpcs_pkg::rec_t cur_reg;
    logic [7:0]     slice_reg;

    logic           done_reg;
    logic           rej_reg;
    logic           run_reg;
    logic [7:0]     rpid_reg;
    logic           fresh_reg;
    logic           fin_reg;
    logic           pre_reg;

    logic [CW-1:0]  idx_p1;
    logic           full;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    mpcs_pkg::rec_t wr_data;
    logic [AW-1:0]  rd_addr;
    mpcs_pkg::rec_t in_rec;
    logic [15:0]    rd_key;
    logic [15:0]    cur_key;
    logic [7:0]     slice_inc;
    logic [7:0]     quantum;
    logic           do_requeue;
    logic [CW+4:0]  count_ext;

    assign idx_p1  = CW'(idx_reg) + CW'(1);
    assign full    = (count_reg == DEPTH_C);
    assign in_rec  = '{pid: pid, arrival: arrival_time, burst_total: burst_length,
                       remaining: burst_length, priority_val: priority_req};
    assign rd_key  = mpcs_pkg::rec_key(rd_data_reg, pol);
    assign cur_key = mpcs_pkg::rec_key(cur_reg, pol);
    assign slice_inc = (slice_reg == 8'hFF) ? slice_reg : slice_reg + 8'd1;
    assign quantum = (time_slice == 8'd0) ? 8'd1 : time_slice;
    assign do_requeue = cmd.requeue && cur_valid_reg && want_reg && !full;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = in_rec;
        if (cmd.push_in && !full)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.shift_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg;
            wr_data = rd_data_reg;
        end
        else if (do_requeue)
        begin
            wr_en   = 1'b1;
            wr_data = cur_reg;
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            mpcs_pkg::RD_NEXT: rd_addr = idx_p1[AW-1:0];
            mpcs_pkg::RD_BEST: rd_addr = best_reg;
            default:           rd_addr = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_best)
        begin
            idx_reg <= best_reg;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_p1[AW-1:0];
        end
        if (cmd.clr)
        begin
            best_reg <= '0;
        end
        else if (cmd.pick_eval && (idx_reg == '0 || rd_key < min_reg))
        begin
            best_reg <= idx_reg;
        end
        if (cmd.pick_eval && (idx_reg == '0 || rd_key < min_reg))
        begin
            min_reg <= rd_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_reg       <= '0;
            slice_reg     <= '0;
            want_reg      <= 1'b0;
            done_reg      <= 1'b0;
            rej_reg       <= 1'b0;
            run_reg       <= 1'b0;
            rpid_reg      <= '0;
            fresh_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            pre_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.done;
            if (cmd.clr)
            begin
                want_reg  <= 1'b0;
                rej_reg   <= 1'b0;
                run_reg   <= 1'b0;
                rpid_reg  <= '0;
                fresh_reg <= 1'b0;
                fin_reg   <= 1'b0;
                pre_reg   <= 1'b0;
            end
            if (cmd.push_in)
            begin
                if (full)
                begin
                    rej_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.take_ld)
            begin
                cur_reg       <= rd_data_reg;
                cur_valid_reg <= 1'b1;
                slice_reg     <= '0;
                fresh_reg     <= 1'b1;
            end
            if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.run && cur_valid_reg)
            begin
                run_reg  <= 1'b1;
                rpid_reg <= cur_reg.pid;
                if (cur_reg.remaining <= 16'd1)
                begin
                    fin_reg       <= 1'b1;
                    cur_valid_reg <= 1'b0;
                    cur_reg       <= '0;
                    slice_reg     <= '0;
                end
                else
                begin
                    cur_reg.remaining <= cur_reg.remaining - 16'd1;
                    if (pol == mpcs_pkg::POL_RR && slice_inc >= quantum)
                    begin
                        want_reg  <= 1'b1;
                        slice_reg <= '0;
                    end
                    else
                    begin
                        slice_reg <= slice_inc;
                    end
                end
            end
            if (cmd.chk_eval && rd_key < cur_key)
            begin
                want_reg <= 1'b1;
            end
            if (do_requeue)
            begin
                count_reg     <= count_reg + CW'(1);
                pre_reg       <= 1'b1;
                cur_valid_reg <= 1'b0;
                cur_reg       <= '0;
                slice_reg     <= '0;
            end
        end
    end

    assign stat.cur_valid   = cur_valid_reg;
    assign stat.has_entries = (count_reg != '0);
    assign stat.is_rr       = (pol == mpcs_pkg::POL_RR);
    assign stat.last        = (idx_p1 >= count_reg);
    assign stat.chk_need    = cur_valid_reg && (cur_reg.remaining > 16'd1) &&
                              (pol == mpcs_pkg::POL_SRTF || pol == mpcs_pkg::POL_PPRI) &&
                              (count_reg != '0);

    assign count_ext       = {5'd0, count_reg};
    assign done            = done_reg;
    assign add_rejected    = rej_reg;
    assign running_valid   = run_reg;
    assign running_pid     = rpid_reg;
    assign newly_scheduled = fresh_reg;
    assign finished        = fin_reg;
    assign preempted       = pre_reg;
    assign ready_count     = count_ext[4:0];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("Ready table count exceeds its depth.");
    a_fin_pre: assert property (@(posedge clk) disable iff (!rst_n)
        !(fin_reg && pre_reg))
        else $error("A process both finished and was requeued.");
    a_rej_norun: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rej_reg |-> !run_reg && !fresh_reg)
        else $error("A rejected arrival reports a running process.");
    a_fresh_run: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg && done_reg |-> run_reg)
        else $error("A newly scheduled process did not run.");
`endif

endmodule

### src/multi_policy_cpu_scheduler.sv
// ----------------------------------------------------------------------------
// multi_policy_cpu_scheduler
// Single-CPU scheduler with FCFS, SJF, priority, round robin, SRTF and preemptive priority policies.
// ----------------------------------------------------------------------------
// A word is accepted on a rising edge with start high and busy low. With func
// low the word is an arrival that is appended to the ready table; with func
// high it is one time tick that may pick a process and then runs it for one
// unit. Every word gives one result word, shown for one cycle while done is
// high; the receiver cannot stall it.
// A tick that needs no pick goes straight to running the current process. A
// pick first searches the table for the minimum key (skipped for round robin),
// then loads the winner and moves every entry behind it down to close the gap.
// SRTF and preemptive priority then test each table entry against the running
// process for a requeue. All of these passes go through the single read port
// of the table memory. busy is high from the cycle after accept until done
// rises.
// Reset clears the table count, the running process and the registers
// (policy FCFS, time slice 4). Registers sit on the APB port at 0 and 4.
// ----------------------------------------------------------------------------
module multi_policy_cpu_scheduler
#(
    parameter int READY_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [7:0]  pid,
    input  logic [15:0] arrival_time,
    input  logic [15:0] burst_length,
    input  logic [7:0]  priority_req,
    output logic        done,
    output logic        add_rejected,
    output logic        running_valid,
    output logic [7:0]  running_pid,
    output logic        newly_scheduled,
    output logic        finished,
    output logic        preempted,
    output logic [4:0]  ready_count
);

    logic [2:0]       policy_reg;
    logic [7:0]       slice_reg;
    logic [2:0]       pol;
    logic             ctrl_start;
    mpcs_pkg::cmd_t   cmd;
    mpcs_pkg::stat_t  stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= mpcs_pkg::POL_FCFS;
            slice_reg  <= 8'd4;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                mpcs_pkg::REG_POLICY: policy_reg <= pwdata[2:0];
                mpcs_pkg::REG_SLICE:  slice_reg  <= pwdata[7:0];
                default:              policy_reg <= policy_reg;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mpcs_pkg::REG_SLICE) ? {24'd0, slice_reg}
                                                      : {29'd0, policy_reg};
    assign pol = (policy_reg > mpcs_pkg::POL_PPRI) ? mpcs_pkg::POL_FCFS : policy_reg;
    assign ctrl_start = start && !busy;

    mpcs_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl_start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    mpcs_dp #(.READY_DEPTH(READY_DEPTH)) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .pol             (pol),
        .time_slice      (slice_reg),
        .pid             (pid),
        .arrival_time    (arrival_time),
        .burst_length    (burst_length),
        .priority_req    (priority_req),
        .done            (done),
        .add_rejected    (add_rejected),
        .running_valid   (running_valid),
        .running_pid     (running_pid),
        .newly_scheduled (newly_scheduled),
        .finished        (finished),
        .preempted       (preempted),
        .ready_count     (ready_count)
    );

endmodule
